// ===== src/sh9_pkg.sv =====
package sh9_pkg;

  localparam int MAX_FACE_SIZE = 1024;
  localparam int SH_TERMS      = 9;
  localparam int FACE_COUNT    = 6;
  localparam int SUM_COUNT     = SH_TERMS * 3;
  localparam int ELEM_COUNT    = 16;
  localparam int SUM_W         = 48;
  localparam int DIV_NUM_W     = 44;
  localparam int DIV_DEN_W     = 23;

  localparam logic [1:0] REG_FACE_WIDTH  = 2'd0;
  localparam logic [1:0] REG_FACE_HEIGHT = 2'd1;

  localparam logic signed [17:0] ONE_Q16 = 18'sd65536;

  localparam logic [16:0] SH_K [SH_TERMS] = '{
    17'd18487, 17'd32021, 17'd32021, 17'd32021, 17'd71601,
    17'd71601, 17'd71601, 17'd20670, 17'd35801
  };

  localparam logic [3:0] ELEM_TERM [ELEM_COUNT] = '{
    4'd8, 4'd4, 4'd7, 4'd3, 4'd4, 4'd8, 4'd5, 4'd1,
    4'd7, 4'd5, 4'd6, 4'd2, 4'd3, 4'd1, 4'd2, 4'd0
  };

  localparam logic signed [18:0] ELEM_MUL [ELEM_COUNT] = '{
    19'sd28118, 19'sd28118, 19'sd28118, 19'sd33532,
    19'sd28118, -19'sd28118, 19'sd28118, 19'sd33532,
    19'sd28118, 19'sd28118, 19'sd48701, 19'sd33532,
    19'sd33532, 19'sd33532, 19'sd33532, 19'sd58080
  };

  localparam logic signed [18:0] KC5 = 19'sd16234;

  typedef enum logic [3:0] {
    ST_IDLE, ST_UDIV, ST_VDIV, ST_AREA, ST_MAP, ST_SQ, ST_MAG,
    ST_NORM, ST_ZSQ, ST_SIN, ST_POLY, ST_TERM, ST_EMIT
  } state_t;

  typedef struct packed {
    logic [2:0]  face_index;
    logic [9:0]  column;
    logic [9:0]  row_number;
    logic [15:0] red_value;
    logic [15:0] green_value;
    logic [15:0] blue_value;
    logic        final_texel;
  } texel_t;

  typedef struct packed {
    logic [3:0]         element_index;
    logic signed [47:0] red_term;
    logic signed [47:0] green_term;
    logic signed [47:0] blue_term;
    logic               last_element;
  } element_t;

  function automatic logic signed [27:0] q16_44(input logic signed [43:0] p);
    logic signed [43:0] t;
    t = p[43] ? p + 44'sd65535 : p;
    return 28'(t >>> 16);
  endfunction

  function automatic logic signed [48:0] q16_65(input logic signed [64:0] p);
    logic signed [64:0] t;
    t = p[64] ? p + 65'sd65535 : p;
    return 49'(t >>> 16);
  endfunction

  function automatic logic signed [47:0] sat48(input logic signed [50:0] v);
    logic signed [47:0] r;
    if (v[50:47] == 4'b0000 || v[50:47] == 4'b1111) begin
      r = v[47:0];
    end else if (v[50]) begin
      r = {1'b1, 47'b0};
    end else begin
      r = {1'b0, {47{1'b1}}};
    end
    return r;
  endfunction

endpackage

// ===== src/sh9_irradiance_projection.sv =====
// Order-2 spherical-harmonic irradiance projection of a cube map.
// Input: pulse start with a texel on texel while busy is low; the transfer
// happens on that edge and busy stays high until the texel is processed and any element output is done.
// Configuration: wr_en/wr_index/wr_data write face_width (0) and face_height
// (1); write only while busy is low. Other indexes are ignored.
// Output: on a texel marked final_texel the block emits sixteen matrix
// elements, each on element for one cycle with done high; last_element marks
// the sixteenth. The receiver cannot stall; every done cycle is a transfer.
// Timing: one shared multiplier, a 1-bit-per-cycle divider and a
// 1-bit-per-cycle square root unit do all work, with 32 divisions per
// texel; a texel on an unknown face needs only the two position divisions.
// A final texel then adds the element output.
// Reset: sums cleared, both sizes 256, block idle.
module sh9_irradiance_projection (
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  output logic              busy,
  input  sh9_pkg::texel_t   texel,
  input  logic              wr_en,
  input  logic [1:0]        wr_index,
  input  logic [10:0]       wr_data,
  output logic              done,
  output sh9_pkg::element_t element
);
  import sh9_pkg::*;

  state_t state, state_next;
  logic [2:0]  ph;
  logic [3:0]  k_idx;
  logic [1:0]  c_idx;
  logic [3:0]  e_idx;
  logic [10:0] face_width, face_height;
  texel_t      item;

  logic [10:0] w_eff, h_eff;
  logic [9:0]  col_sat, row_sat;
  logic signed [17:0] u_val, v_val, cx, cy, cz, comp_sel, comp_abs;
  logic [22:0] area;
  logic [34:0] sumsq;
  logic [17:0] mag;
  logic [32:0] zrad;
  logic [17:0] s_val;
  logic signed [17:0] m_xy, m_yz, m_zz, m_xz, m_xx, m_yy;
  logic signed [18:0] t1, wt, p_sel;
  logic        tsign;
  logic signed [64:0] wide;
  logic signed [50:0] ev;
  logic signed [47:0] sums [SUM_COUNT];
  logic signed [47:0] sum_rd, sum_new;
  logic [4:0]  sum_addr;
  logic        sum_we, sum_clear;

  logic signed [24:0] mul_a;
  logic signed [18:0] mul_b;
  logic signed [43:0] mul_p, p_abs;
  logic signed [27:0] mq;
  logic signed [48:0] emit_v;
  logic signed [47:0] emit_val;
  logic        emit_store;
  logic signed [44:0] term;
  logic [15:0] rad_c;
  logic [13:0] w_six;

  logic                 div_go, div_busy;
  logic [DIV_NUM_W-1:0] div_num, div_quo;
  logic [DIV_DEN_W-1:0] div_den;

  logic        sq_go, sq_busy;
  logic [35:0] sq_in, sq_rad;
  logic [18:0] sq_rem;
  logic [17:0] sq_root;
  logic [4:0]  sq_cnt;
  logic [20:0] sq_rem_sh, sq_trial, sq_diff;

  sh9_div u_div (
    .clk  (clk),
    .rst  (rst),
    .go   (div_go),
    .num  (div_num),
    .den  (div_den),
    .busy (div_busy),
    .quo  (div_quo)
  );

  assign busy = state != ST_IDLE;

  always_comb begin
    if (face_width == '0) w_eff = 11'd1;
    else if (face_width > 11'(MAX_FACE_SIZE)) w_eff = 11'(MAX_FACE_SIZE);
    else w_eff = face_width;
    if (face_height == '0) h_eff = 11'd1;
    else if (face_height > 11'(MAX_FACE_SIZE)) h_eff = 11'(MAX_FACE_SIZE);
    else h_eff = face_height;
  end

  assign col_sat = ({1'b0, item.column} > w_eff - 11'd1) ? 10'(w_eff - 11'd1)
                                                          : item.column;
  assign row_sat = ({1'b0, item.row_number} > h_eff - 11'd1) ? 10'(h_eff - 11'd1)
                                                              : item.row_number;
  assign w_six = 14'(w_eff) * 14'(FACE_COUNT);

  always_comb begin
    unique case (c_idx)
      2'd0:    comp_sel = cx;
      2'd1:    comp_sel = cy;
      default: comp_sel = cz;
    endcase
    unique case (c_idx)
      2'd0:    rad_c = item.red_value;
      2'd1:    rad_c = item.green_value;
      default: rad_c = item.blue_value;
    endcase
  end
  assign comp_abs = comp_sel[17] ? -comp_sel : comp_sel;

  always_comb begin
    unique case (k_idx)
      4'd0:    p_sel = 19'(ONE_Q16);
      4'd1:    p_sel = 19'(cy);
      4'd2:    p_sel = 19'(cz);
      4'd3:    p_sel = 19'(cx);
      4'd4:    p_sel = 19'(m_xy);
      4'd5:    p_sel = 19'(m_yz);
      4'd6:    p_sel = 19'(m_zz) * 19'sd3 - 19'sd65536;
      4'd7:    p_sel = 19'(m_xz);
      4'd8:    p_sel = 19'(m_xx) - 19'(m_yy);
      default: p_sel = '0;
    endcase
  end

  assign mq       = q16_44(mul_p);
  assign p_abs    = mul_p[43] ? -mul_p : mul_p;
  assign emit_v   = q16_65(wide + 65'(mul_p));
  assign emit_val = (e_idx == 4'd15) ? sat48(ev - 51'(emit_v)) : sat48(51'(emit_v));
  assign emit_store = state == ST_EMIT && ((e_idx == 4'd15) ? ph == 3'd5 : ph == 3'd2);
  assign term     = tsign ? -$signed({1'b0, div_quo}) : $signed({1'b0, div_quo});
  assign sum_rd   = (sum_addr < 5'(SUM_COUNT)) ? sums[sum_addr] : '0;
  assign sum_new  = sat48(51'(sum_rd) + 51'(term));
  assign sum_we   = state == ST_TERM && ph == 3'd6 && !div_busy;
  assign sum_clear = emit_store && c_idx == 2'd2 && e_idx == 4'd15;

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: if (start) state_next = ST_UDIV;
      ST_UDIV: if (ph == 3'd1 && !div_busy) state_next = ST_VDIV;
      ST_VDIV: if (ph == 3'd1 && !div_busy) state_next = ST_AREA;
      ST_AREA: if (ph == 3'd1) state_next = ST_MAP;
      ST_MAP: begin
        if (item.face_index >= 3'(FACE_COUNT)) begin
          state_next = item.final_texel ? ST_EMIT : ST_IDLE;
        end else begin
          state_next = ST_SQ;
        end
      end
      ST_SQ:   if (ph == 3'd3) state_next = ST_MAG;
      ST_MAG:  if (ph == 3'd1 && !sq_busy) state_next = ST_NORM;
      ST_NORM: if (ph == 3'd1 && !div_busy && c_idx == 2'd2) state_next = ST_ZSQ;
      ST_ZSQ:  if (ph == 3'd1) state_next = ST_SIN;
      ST_SIN:  if (ph == 3'd1 && !sq_busy) state_next = ST_POLY;
      ST_POLY: if (ph == 3'd6) state_next = ST_TERM;
      ST_TERM: begin
        if (sum_we && c_idx == 2'd2 && k_idx == 4'(SH_TERMS - 1)) begin
          state_next = item.final_texel ? ST_EMIT : ST_IDLE;
        end
      end
      ST_EMIT: if (sum_clear) state_next = ST_IDLE;
      default: state_next = ST_IDLE;
    endcase
  end

  // shared units
  always_comb begin
    mul_a    = '0;
    mul_b    = '0;
    div_go   = 1'b0;
    div_num  = '0;
    div_den  = '0;
    sq_go    = 1'b0;
    sq_in    = '0;
    sum_addr = {1'b0, k_idx} + {k_idx, 1'b0} + {3'b0, c_idx};
    unique case (state)
      ST_UDIV: begin
        div_go  = ph == 3'd0;
        div_num = {17'b0, col_sat, 17'b0};
        div_den = {12'b0, w_eff};
      end
      ST_VDIV: begin
        div_go  = ph == 3'd0;
        div_num = {17'b0, row_sat, 17'b0};
        div_den = {12'b0, h_eff};
      end
      ST_AREA: begin
        mul_a = $signed({11'b0, w_six});
        mul_b = $signed({8'b0, h_eff});
      end
      ST_SQ: begin
        unique case (ph)
          3'd0: begin mul_a = 25'(cx); mul_b = 19'(cx); end
          3'd1: begin mul_a = 25'(cy); mul_b = 19'(cy); end
          3'd2: begin mul_a = 25'(cz); mul_b = 19'(cz); end
          default: ;
        endcase
      end
      ST_MAG: begin
        sq_go = ph == 3'd0;
        sq_in = {1'b0, sumsq};
      end
      ST_NORM: begin
        div_go  = ph == 3'd0;
        div_num = {11'b0, comp_abs[16:0], 16'b0} + {27'b0, mag[17:1]};
        div_den = {5'b0, mag};
      end
      ST_ZSQ: begin
        mul_a = 25'(cz);
        mul_b = 19'(cz);
      end
      ST_SIN: begin
        sq_go = ph == 3'd0;
        sq_in = {3'b0, zrad};
      end
      ST_POLY: begin
        unique case (ph)
          3'd0: begin mul_a = 25'(cx); mul_b = 19'(cy); end
          3'd1: begin mul_a = 25'(cy); mul_b = 19'(cz); end
          3'd2: begin mul_a = 25'(cz); mul_b = 19'(cz); end
          3'd3: begin mul_a = 25'(cx); mul_b = 19'(cz); end
          3'd4: begin mul_a = 25'(cx); mul_b = 19'(cx); end
          3'd5: begin mul_a = 25'(cy); mul_b = 19'(cy); end
          default: ;
        endcase
      end
      ST_TERM: begin
        unique case (ph)
          3'd0: begin mul_a = $signed({8'b0, SH_K[k_idx]}); mul_b = p_sel; end
          3'd2: begin mul_a = $signed({7'b0, s_val}); mul_b = t1; end
          3'd4: begin mul_a = $signed({9'b0, rad_c}); mul_b = wt; end
          3'd5: begin
            div_go  = 1'b1;
            div_num = {p_abs[35:0], 8'b0};
            div_den = area;
          end
          default: ;
        endcase
      end
      ST_EMIT: begin
        if (ph < 3'd3) begin
          sum_addr = {1'b0, ELEM_TERM[e_idx]} + {ELEM_TERM[e_idx], 1'b0}
                   + {3'b0, c_idx};
        end else begin
          sum_addr = 5'd18 + {3'b0, c_idx};
        end
        unique case (ph)
          3'd0: begin mul_a = $signed({sum_rd[47], sum_rd[47:24]});
                      mul_b = ELEM_MUL[e_idx]; end
          3'd1: begin mul_a = $signed({1'b0, sum_rd[23:0]});
                      mul_b = ELEM_MUL[e_idx]; end
          3'd3: begin mul_a = $signed({sum_rd[47], sum_rd[47:24]}); mul_b = KC5; end
          3'd4: begin mul_a = $signed({1'b0, sum_rd[23:0]}); mul_b = KC5; end
          default: ;
        endcase
      end
      default: ;
    endcase
  end

  // control
  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= ST_IDLE;
      ph          <= '0;
      k_idx       <= '0;
      c_idx       <= '0;
      e_idx       <= '0;
      done        <= 1'b0;
      face_width  <= 11'd256;
      face_height <= 11'd256;
    end else begin
      state <= state_next;
      done  <= emit_store && c_idx == 2'd2;
      if (wr_en) begin
        unique case (wr_index)
          REG_FACE_WIDTH:  face_width  <= wr_data;
          REG_FACE_HEIGHT: face_height <= wr_data;
          default: ;
        endcase
      end
      unique case (state)
        ST_IDLE: begin
          ph <= '0; k_idx <= '0; c_idx <= '0; e_idx <= '0;
        end
        ST_UDIV, ST_VDIV: begin
          if (ph == 3'd0) ph <= 3'd1;
          else if (!div_busy) ph <= '0;
        end
        ST_MAG, ST_SIN: begin
          if (ph == 3'd0) ph <= 3'd1;
          else if (!sq_busy) ph <= '0;
        end
        ST_AREA, ST_ZSQ: ph <= (ph == 3'd0) ? 3'd1 : 3'd0;
        ST_MAP:  ph <= '0;
        ST_SQ:   ph <= (ph == 3'd3) ? 3'd0 : ph + 3'd1;
        ST_POLY: ph <= (ph == 3'd6) ? 3'd0 : ph + 3'd1;
        ST_NORM: begin
          if (ph == 3'd0) begin
            ph <= 3'd1;
          end else if (!div_busy) begin
            ph    <= '0;
            c_idx <= (c_idx == 2'd2) ? 2'd0 : c_idx + 2'd1;
          end
        end
        ST_TERM: begin
          if (ph != 3'd6) begin
            ph <= ph + 3'd1;
          end else if (!div_busy) begin
            if (c_idx != 2'd2) begin
              c_idx <= c_idx + 2'd1;
              ph    <= 3'd4;
            end else begin
              c_idx <= '0;
              ph    <= '0;
              k_idx <= (k_idx == 4'(SH_TERMS - 1)) ? 4'd0 : k_idx + 4'd1;
            end
          end
        end
        ST_EMIT: begin
          if (emit_store) begin
            ph <= '0;
            if (c_idx != 2'd2) begin
              c_idx <= c_idx + 2'd1;
            end else begin
              c_idx <= '0;
              e_idx <= e_idx + 4'd1;
            end
          end else begin
            ph <= ph + 3'd1;
          end
        end
        default: ph <= '0;
      endcase
    end
  end

  // datapath
  always_ff @(posedge clk) begin
    mul_p <= mul_a * mul_b;
    if (state == ST_IDLE && start) item <= texel;
    unique case (state)
      ST_UDIV: if (ph == 3'd1 && !div_busy) u_val <= $signed(div_quo[17:0] - 18'd65536);
      ST_VDIV: if (ph == 3'd1 && !div_busy) v_val <= $signed(div_quo[17:0] - 18'd65536);
      ST_AREA: if (ph == 3'd1) area <= mul_p[22:0];
      ST_MAP: begin
        sumsq <= '0;
        unique case (item.face_index)
          3'd0: begin cx <= ONE_Q16;  cy <= v_val;    cz <= -u_val;   end
          3'd1: begin cx <= -ONE_Q16; cy <= v_val;    cz <= u_val;    end
          3'd2: begin cx <= u_val;    cy <= ONE_Q16;  cz <= -v_val;   end
          3'd3: begin cx <= u_val;    cy <= -ONE_Q16; cz <= v_val;    end
          3'd4: begin cx <= -u_val;   cy <= v_val;    cz <= ONE_Q16;  end
          3'd5: begin cx <= u_val;    cy <= v_val;    cz <= -ONE_Q16; end
          default: ;
        endcase
      end
      ST_SQ: if (ph != 3'd0) sumsq <= sumsq + mul_p[34:0];
      ST_MAG: if (ph == 3'd1 && !sq_busy) mag <= sq_root;
      ST_NORM: begin
        if (ph == 3'd1 && !div_busy) begin
          unique case (c_idx)
            2'd0: cx <= comp_sel[17] ? -$signed(div_quo[17:0]) : $signed(div_quo[17:0]);
            2'd1: cy <= comp_sel[17] ? -$signed(div_quo[17:0]) : $signed(div_quo[17:0]);
            default: cz <= comp_sel[17] ? -$signed(div_quo[17:0])
                                        : $signed(div_quo[17:0]);
          endcase
        end
      end
      ST_ZSQ: begin
        if (ph == 3'd1) begin
          zrad <= (mul_p[32:0] >= 33'h1_0000_0000) ? 33'd0
                                                   : 33'h1_0000_0000 - mul_p[32:0];
        end
      end
      ST_SIN: if (ph == 3'd1 && !sq_busy) s_val <= sq_root;
      ST_POLY: begin
        unique case (ph)
          3'd1: m_xy <= mq[17:0];
          3'd2: m_yz <= mq[17:0];
          3'd3: m_zz <= mq[17:0];
          3'd4: m_xz <= mq[17:0];
          3'd5: m_xx <= mq[17:0];
          3'd6: m_yy <= mq[17:0];
          default: ;
        endcase
      end
      ST_TERM: begin
        unique case (ph)
          3'd1: t1 <= mq[18:0];
          3'd3: wt <= mq[18:0];
          3'd5: tsign <= mul_p[43];
          default: ;
        endcase
      end
      ST_EMIT: begin
        if (ph == 3'd1 || ph == 3'd4) wide <= 65'(mul_p) <<< 24;
        if (ph == 3'd2 && e_idx == 4'd15) ev <= 51'(emit_v);
        if (emit_store) begin
          element.element_index <= e_idx;
          element.last_element  <= e_idx == 4'd15;
          unique case (c_idx)
            2'd0:    element.red_term   <= emit_val;
            2'd1:    element.green_term <= emit_val;
            default: element.blue_term  <= emit_val;
          endcase
        end
      end
      default: ;
    endcase
  end

  // coefficient sums
  always_ff @(posedge clk) begin
    if (rst || sum_clear) begin
      for (int i = 0; i < SUM_COUNT; i++) sums[i] <= '0;
    end else if (sum_we) begin
      sums[sum_addr] <= sum_new;
    end
  end

  // square root, one result bit per cycle
  assign sq_rem_sh = {sq_rem, sq_rad[35:34]};
  assign sq_trial  = {1'b0, sq_root, 2'b01};
  assign sq_diff   = sq_rem_sh - sq_trial;

  always_ff @(posedge clk) begin
    if (rst) begin
      sq_busy <= 1'b0;
    end else if (sq_go) begin
      sq_busy <= 1'b1;
    end else if (sq_busy && sq_cnt == '0) begin
      sq_busy <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (sq_go) begin
      sq_rad  <= sq_in;
      sq_rem  <= '0;
      sq_root <= '0;
      sq_cnt  <= 5'd17;
    end else if (sq_busy) begin
      if (sq_rem_sh >= sq_trial) begin
        sq_rem  <= sq_diff[18:0];
        sq_root <= {sq_root[16:0], 1'b1};
      end else begin
        sq_rem  <= sq_rem_sh[18:0];
        sq_root <= {sq_root[16:0], 1'b0};
      end
      sq_rad <= {sq_rad[33:0], 2'b00};
      sq_cnt <= sq_cnt - 5'd1;
    end
  end

  a_done_single: assert property (@(posedge clk) disable iff (rst)
    done |-> !$past(done))
    else $error("result strobe held for two cycles");

  a_last_idle: assert property (@(posedge clk) disable iff (rst)
    done && element.last_element |-> state == ST_IDLE)
    else $error("block still busy after last element");

  a_div_free: assert property (@(posedge clk) disable iff (rst)
    div_go |-> !div_busy)
    else $error("divider started while busy");

  a_sqrt_free: assert property (@(posedge clk) disable iff (rst)
    sq_go |-> !sq_busy)
    else $error("square root started while busy");

endmodule

// ===== src/sh9_div.sv =====
module sh9_div (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          go,
  input  logic [sh9_pkg::DIV_NUM_W-1:0] num,
  input  logic [sh9_pkg::DIV_DEN_W-1:0] den,
  output logic                          busy,
  output logic [sh9_pkg::DIV_NUM_W-1:0] quo
);
  import sh9_pkg::*;

  localparam int CNT_W = $clog2(DIV_NUM_W);

  logic [DIV_DEN_W-1:0] rem;
  logic [DIV_DEN_W-1:0] den_q;
  logic [CNT_W-1:0]     cnt;
  logic [DIV_DEN_W:0]   rem_sh;
  logic [DIV_DEN_W:0]   diff;
  logic                 take;

  assign rem_sh = {rem, quo[DIV_NUM_W-1]};
  assign diff   = rem_sh - {1'b0, den_q};
  assign take   = rem_sh >= {1'b0, den_q};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
    end else if (go) begin
      busy <= 1'b1;
    end else if (busy && cnt == '0) begin
      busy <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (go) begin
      rem   <= '0;
      quo   <= num;
      den_q <= den;
      cnt   <= CNT_W'(DIV_NUM_W - 1);
    end else if (busy) begin
      rem <= take ? diff[DIV_DEN_W-1:0] : rem_sh[DIV_DEN_W-1:0];
      quo <= {quo[DIV_NUM_W-2:0], take};
      cnt <= cnt - 1'b1;
    end
  end

endmodule

// ===== bench/tb_top.sv =====
`timescale 1ns / 1ps
module tb_top;
  import sh9_pkg::*;

  localparam longint SAT_HI = 64'sh0000_7FFF_FFFF_FFFF;
  localparam longint SAT_LO = -SAT_HI - 1;
  localparam longint LIMIT = 3_000_000;
  localparam int SETTLE = 2000;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic start = 1'b0;
  logic busy;
  texel_t texel = '0;
  logic wr_en = 1'b0;
  logic [1:0] wr_index = REG_FACE_WIDTH;
  logic [10:0] wr_data = '0;
  logic done;
  element_t element;

  sh9_irradiance_projection dut (
    .clk(clk), .rst(rst), .start(start), .busy(busy), .texel(texel),
    .wr_en(wr_en), .wr_index(wr_index), .wr_data(wr_data),
    .done(done), .element(element)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  texel_t pending_texels[$];
  element_t expected_elements[$];
  longint sh_sums[SUM_COUNT];
  longint unsigned width_reg = 256, height_reg = 256;
  int gap_pct = 0;
  int errors = 0;
  int texels_taken = 0, elements_seen = 0, finals_sent = 0;
  longint cycles = 0;

  function automatic longint unsigned int_sqrt(longint unsigned n);
    longint unsigned r, b;
    r = 0;
    b = 64'd1 << 62;
    while (b > n) b >>= 2;
    while (b != 0) begin
      if (n >= r + b) begin
        n -= r + b;
        r = (r >> 1) + b;
      end else begin
        r >>= 1;
      end
      b >>= 2;
    end
    return r;
  endfunction

  function automatic longint q16_mul(longint a, longint b);
    return (a * b) / 65536;
  endfunction

  function automatic longint clamp48(longint v);
    if (v > SAT_HI) return SAT_HI;
    if (v < SAT_LO) return SAT_LO;
    return v;
  endfunction

  function automatic longint unsigned legal_size(longint unsigned s);
    if (s == 0) return 1;
    if (s > MAX_FACE_SIZE) return MAX_FACE_SIZE;
    return s;
  endfunction

  function automatic longint face_pos(longint unsigned pos, longint unsigned size);
    if (pos > size - 1) pos = size - 1;
    return longint'((pos * 2 * 65536) / size) - 65536;
  endfunction

  function automatic longint unit_comp(longint a, longint unsigned mag);
    longint unsigned m, q;
    m = (a < 0) ? longint'(-a) : a;
    q = (m * 65536 + mag / 2) / mag;
    return (a < 0) ? -longint'(q) : longint'(q);
  endfunction

  task automatic project_texel(input texel_t t);
    longint unsigned w, h, mag, s, zz, area;
    longint u, v, x, y, z, wt, contrib;
    longint p[SH_TERMS];
    longint unsigned rad[3];
    longint val;
    element_t el;
    w = legal_size(width_reg);
    h = legal_size(height_reg);
    u = face_pos(t.column, w);
    v = face_pos(t.row_number, h);
    rad[0] = t.red_value;
    rad[1] = t.green_value;
    rad[2] = t.blue_value;
    if (t.face_index < 6) begin
      case (t.face_index)
        3'd0: begin x = 65536; y = v; z = -u; end
        3'd1: begin x = -65536; y = v; z = u; end
        3'd2: begin x = u; y = 65536; z = -v; end
        3'd3: begin x = u; y = -65536; z = v; end
        3'd4: begin x = -u; y = v; z = 65536; end
        default: begin x = u; y = v; z = -65536; end
      endcase
      mag = int_sqrt(x * x + y * y + z * z);
      if (mag == 0) mag = 1;
      x = unit_comp(x, mag);
      y = unit_comp(y, mag);
      z = unit_comp(z, mag);
      zz = z * z;
      s = int_sqrt(zz >= 64'h1_0000_0000 ? 0 : 64'h1_0000_0000 - zz);
      p[0] = 65536; p[1] = y; p[2] = z; p[3] = x;
      p[4] = q16_mul(x, y);
      p[5] = q16_mul(y, z);
      p[6] = 3 * q16_mul(z, z) - 65536;
      p[7] = q16_mul(x, z);
      p[8] = q16_mul(x, x) - q16_mul(y, y);
      area = 6 * w * h;
      for (int k = 0; k < SH_TERMS; k++) begin
        wt = q16_mul(q16_mul(longint'(SH_K[k]), p[k]), longint'(s));
        for (int c = 0; c < 3; c++) begin
          contrib = (wt * longint'(rad[c]) * 256) / longint'(area);
          sh_sums[k * 3 + c] = clamp48(sh_sums[k * 3 + c] + contrib);
        end
      end
    end
    if (t.final_texel) begin
      for (int e = 0; e < ELEM_COUNT; e++) begin
        el.element_index = 4'(e);
        el.last_element = (e == ELEM_COUNT - 1);
        for (int c = 0; c < 3; c++) begin
          val = q16_mul(longint'(ELEM_MUL[e]), sh_sums[ELEM_TERM[e] * 3 + c]);
          if (e == ELEM_COUNT - 1) val -= q16_mul(longint'(KC5), sh_sums[6 * 3 + c]);
          val = clamp48(val);
          case (c)
            0: el.red_term = val[47:0];
            1: el.green_term = val[47:0];
            default: el.blue_term = val[47:0];
          endcase
        end
        expected_elements.push_back(el);
      end
      for (int i = 0; i < SUM_COUNT; i++) sh_sums[i] = 0;
    end
  endtask

  // texel transfer side
  always @(posedge clk) begin
    if (rst) begin
      start <= 1'b0;
    end else begin
      if (start && !busy) begin
        project_texel(texel);
        texels_taken++;
      end
      if (!(start && busy)) begin
        if (pending_texels.size() > 0 && $urandom_range(99) >= gap_pct) begin
          start <= 1'b1;
          texel <= pending_texels.pop_front();
        end else begin
          start <= 1'b0;
        end
      end
    end
  end

  // element transfer side
  always @(posedge clk) begin
    element_t exp_el;
    cycles++;
    if (!rst && done) begin
      elements_seen++;
      if (expected_elements.size() == 0) begin
        $error("unexpected element %0d", element.element_index);
        errors++;
      end else begin
        exp_el = expected_elements.pop_front();
        if (element.element_index !== exp_el.element_index) begin
          $error("element_index exp %0d got %0d", exp_el.element_index,
                 element.element_index);
          errors++;
        end
        if (element.red_term !== exp_el.red_term) begin
          $error("red_term exp %0d got %0d", exp_el.red_term, element.red_term);
          errors++;
        end
        if (element.green_term !== exp_el.green_term) begin
          $error("green_term exp %0d got %0d", exp_el.green_term, element.green_term);
          errors++;
        end
        if (element.blue_term !== exp_el.blue_term) begin
          $error("blue_term exp %0d got %0d", exp_el.blue_term, element.blue_term);
          errors++;
        end
        if (element.last_element !== exp_el.last_element) begin
          $error("last_element exp %0d got %0d", exp_el.last_element,
                 element.last_element);
          errors++;
        end
      end
    end
    if (cycles > LIMIT) begin
      $display("Simulation FAILED");
      $finish;
    end
  end

  function automatic texel_t make_texel(int f, int col, int rw, int r, int g, int b, bit fin);
    texel_t t;
    t.face_index = 3'(f);
    t.column = 10'(col);
    t.row_number = 10'(rw);
    t.red_value = 16'(r);
    t.green_value = 16'(g);
    t.blue_value = 16'(b);
    t.final_texel = fin;
    if (fin) finals_sent++;
    return t;
  endfunction

  task automatic push_random(int n);
    int f;
    for (int i = 0; i < n; i++) begin
      f = ($urandom_range(9) == 0) ? $urandom_range(7, 6) : $urandom_range(5);
      pending_texels.push_back(make_texel(f, $urandom_range(1023), $urandom_range(1023),
        $urandom_range(65535), $urandom_range(65535), $urandom_range(65535),
        (i == n - 1) || ($urandom_range(7) == 0)));
    end
  endtask

  task automatic drain();
    while (pending_texels.size() > 0 || start || busy || expected_elements.size() > 0)
      @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic write_reg(logic [1:0] idx, logic [10:0] data);
    @(posedge clk);
    wr_en <= 1'b1;
    wr_index <= idx;
    wr_data <= data;
    if (idx == REG_FACE_WIDTH) width_reg = data;
    else if (idx == REG_FACE_HEIGHT) height_reg = data;
    @(posedge clk);
    wr_en <= 1'b0;
  endtask

  task automatic set_size(logic [10:0] w, logic [10:0] h);
    write_reg(REG_FACE_WIDTH, w);
    write_reg(REG_FACE_HEIGHT, h);
  endtask

  initial begin
    for (int i = 0; i < SUM_COUNT; i++) sh_sums[i] = 0;
    repeat (6) @(posedge clk);
    rst <= 1'b0;

    // reset sizes: every face, unknown faces, field extremes
    gap_pct = 26;
    for (int f = 0; f < 8; f++)
      pending_texels.push_back(make_texel(f, f * 37, 1023 - f * 41,
        16'hFFFF, f * 9000, 0, 1'b0));
    pending_texels.push_back(make_texel(0, 0, 0, 0, 0, 0, 1'b0));
    pending_texels.push_back(make_texel(5, 1023, 1023, 16'hFFFF, 16'hFFFF, 16'hFFFF, 1'b1));
    pending_texels.push_back(make_texel(7, 5, 5, 16'hFFFF, 1, 2, 1'b1));
    drain();

    // zero width, oversize height, ignored indexes, positions past the face
    set_size(11'd0, 11'd2047);
    write_reg(2'd2, 11'd5);
    write_reg(2'd3, 11'd7);
    pending_texels.push_back(make_texel(2, 1023, 1023, 16'hFFFF, 16'h8000, 1, 1'b0));
    pending_texels.push_back(make_texel(3, 0, 512, 16'h1234, 16'hFFFF, 16'hFFFF, 1'b0));
    pending_texels.push_back(make_texel(4, 700, 0, 16'hFFFF, 0, 16'hFFFF, 1'b1));
    drain();

    set_size(11'd1024, 11'd1024);
    push_random(60);
    drain();
    push_random(60);
    drain();

    gap_pct = 72;
    set_size(11'd1, 11'd1);
    push_random(40);
    drain();
    set_size(11'($urandom_range(2, 64)), 11'($urandom_range(2, 64)));
    push_random(120);
    drain();

    gap_pct = 0;
    set_size(11'd1024, 11'd3);
    push_random(40);
    drain();
    set_size(11'($urandom_range(1, 1024)), 11'($urandom_range(1, 1024)));
    push_random(140);
    drain();

    $display("Covered %0d texels over several face sizes, %0d final marks, %0d elements",
             texels_taken, finals_sent, elements_seen);
    if (errors == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
src/sh9_pkg.sv
src/sh9_div.sv
src/sh9_irradiance_projection.sv
bench/tb_top.sv
